// ===== hdl/srp_pkg.sv =====
// Shared types, constants and the control store for the shelf rectangle packer.
// Depends on nothing; the packer top level refers to it by scoped names.

package srp_pkg;

   // Field widths fixed by the interface.
   localparam int unsigned DIM_W     = 14;
   localparam int unsigned PAD_W     = 4;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned PAGE_W    = 3;
   localparam int unsigned CSR_IDX_W = 2;
   // Wide enough for a cursor plus a size plus three paddings without wrap.
   localparam int unsigned SUM_W     = 16;

   localparam int unsigned MaxPagesDefault = 8;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDING     = 2'd2;

   // Reset values of the configuration registers and of the first page.
   localparam logic [DIM_W-1:0] PAGE_DIM_RESET = 14'd2048;
   localparam logic [PAD_W-1:0] PADDING_RESET  = 4'd1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_PLACED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_BIG = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   // Step addresses of the control program.
   localparam int unsigned STEP_W = 4;
   localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
   localparam logic [STEP_W-1:0] S_BIG  = 4'd1;
   localparam logic [STEP_W-1:0] S_LOOP = 4'd2;
   localparam logic [STEP_W-1:0] S_WID  = 4'd3;
   localparam logic [STEP_W-1:0] S_HGT  = 4'd4;
   localparam logic [STEP_W-1:0] S_OPEN = 4'd5;
   localparam logic [STEP_W-1:0] S_WID2 = 4'd6;
   localparam logic [STEP_W-1:0] S_HGT2 = 4'd7;
   localparam logic [STEP_W-1:0] S_OUT  = 4'd8;

   // Datapath operations.
   localparam int unsigned OP_W = 3;
   localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 3'd1;
   localparam logic [OP_W-1:0] OP_BIG   = 3'd2;
   localparam logic [OP_W-1:0] OP_WIDTH = 3'd3;
   localparam logic [OP_W-1:0] OP_PLACE = 3'd4;
   localparam logic [OP_W-1:0] OP_OPEN  = 3'd5;
   localparam logic [OP_W-1:0] OP_EMIT  = 3'd6;

   // Jump conditions.
   localparam int unsigned CND_W = 3;
   localparam logic [CND_W-1:0] C_ALWAYS = 3'd0;
   localparam logic [CND_W-1:0] C_REQ    = 3'd1;
   localparam logic [CND_W-1:0] C_BIG    = 3'd2;
   localparam logic [CND_W-1:0] C_END    = 3'd3;
   localparam logic [CND_W-1:0] C_FIT    = 3'd4;
   localparam logic [CND_W-1:0] C_FULL   = 3'd5;
   localparam logic [CND_W-1:0] C_EMIT   = 3'd6;

   // One control word: an operation, a condition, and the targets taken
   // when the condition holds or fails.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CND_W-1:0]  cnd;
      logic [STEP_W-1:0] jt;
      logic [STEP_W-1:0] jf;
   } ctrl_word_type;

   // The control program. Pages are walked by LOOP, WID and HGT; a freshly
   // opened page runs through WID2 and HGT2, which never loop back.
   function automatic ctrl_word_type mc_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      unique case (step)
         S_IDLE:  cw = '{op: OP_LOAD,  cnd: C_REQ,    jt: S_BIG,  jf: S_IDLE};
         S_BIG:   cw = '{op: OP_BIG,   cnd: C_BIG,    jt: S_OUT,  jf: S_LOOP};
         S_LOOP:  cw = '{op: OP_NOP,   cnd: C_END,    jt: S_OPEN, jf: S_WID};
         S_WID:   cw = '{op: OP_WIDTH, cnd: C_ALWAYS, jt: S_HGT,  jf: S_HGT};
         S_HGT:   cw = '{op: OP_PLACE, cnd: C_FIT,    jt: S_OUT,  jf: S_LOOP};
         S_OPEN:  cw = '{op: OP_OPEN,  cnd: C_FULL,   jt: S_OUT,  jf: S_WID2};
         S_WID2:  cw = '{op: OP_WIDTH, cnd: C_ALWAYS, jt: S_HGT2, jf: S_HGT2};
         S_HGT2:  cw = '{op: OP_PLACE, cnd: C_ALWAYS, jt: S_OUT,  jf: S_OUT};
         S_OUT:   cw = '{op: OP_EMIT,  cnd: C_EMIT,   jt: S_IDLE, jf: S_OUT};
         default: cw = '{op: OP_NOP,   cnd: C_ALWAYS, jt: S_IDLE, jf: S_IDLE};
      endcase
      return cw;
   endfunction

endpackage

// ===== hdl/shelf_rect_packer_unit.sv =====
// Shelf rectangle packer: a microcoded sequencer placing rectangles on atlas pages.
// Depends on srp_pkg for widths, codes and the control program.
//
// An accepted request goes to the size check, which sends a too big one straight to
// the result step; else the page walk (LOOP, WID, HGT) tries each open page, and OPEN
// then opens a fresh page for WID2 and HGT2 or reports a full atlas. Requests are
// taken only in the idle step; the result step waits while the output register holds
// a word. Synchronous reset restores the register defaults and one open page.

module shelf_rect_packer_unit #(
   parameter int unsigned MAX_PAGES = srp_pkg::MaxPagesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [srp_pkg::DIM_W-1:0]      req_rect_width,
   input  logic [srp_pkg::DIM_W-1:0]      req_rect_height,
   // Result channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [srp_pkg::STATUS_W-1:0]   rsp_status,
   output logic [srp_pkg::PAGE_W-1:0]     rsp_page_num,
   output logic [srp_pkg::DIM_W-1:0]      rsp_pos_x,
   output logic [srp_pkg::DIM_W-1:0]      rsp_pos_y,
   // Configuration channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [srp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [srp_pkg::DIM_W-1:0]      csr_wdata
);

   localparam int unsigned CNT_W  = $clog2(MAX_PAGES + 1);
   localparam int unsigned IDX_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam int unsigned DIM_W  = srp_pkg::DIM_W;
   localparam int unsigned SUM_W  = srp_pkg::SUM_W;
   localparam int unsigned PAGE_W = srp_pkg::PAGE_W;

   // Sequencer and configuration registers.
   logic [srp_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [DIM_W-1:0]             page_width_ff, page_width_in;
   logic [DIM_W-1:0]             page_height_ff, page_height_in;
   logic [srp_pkg::PAD_W-1:0]    padding_ff, padding_in;

   // Page cursors and page walk.
   logic [DIM_W-1:0]             cursor_x_ff [MAX_PAGES];
   logic [DIM_W-1:0]             cursor_x_in [MAX_PAGES];
   logic [DIM_W-1:0]             cursor_y_ff [MAX_PAGES];
   logic [DIM_W-1:0]             cursor_y_in [MAX_PAGES];
   logic [DIM_W-1:0]             shelf_ff [MAX_PAGES];
   logic [DIM_W-1:0]             shelf_in [MAX_PAGES];
   logic [CNT_W-1:0]             pages_open_ff, pages_open_in;
   logic [CNT_W-1:0]             page_ff, page_in;

   // Working copy of the request and its result.
   logic [DIM_W-1:0]             rect_w_ff, rect_w_in;
   logic [DIM_W-1:0]             rect_h_ff, rect_h_in;
   logic [srp_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [srp_pkg::PAGE_W-1:0]   res_page_ff, res_page_in;
   logic [DIM_W-1:0]             res_x_ff, res_x_in;
   logic [DIM_W-1:0]             res_y_ff, res_y_in;

   // Output register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [srp_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [srp_pkg::PAGE_W-1:0]   rsp_page_ff, rsp_page_in;
   logic [DIM_W-1:0]             rsp_x_ff, rsp_x_in;
   logic [DIM_W-1:0]             rsp_y_ff, rsp_y_in;

   srp_pkg::ctrl_word_type       cw;
   logic                         cond;
   logic                         req_take;
   logic                         emit_ok;
   logic [IDX_W-1:0]             p_idx;
   logic [DIM_W-1:0]             cur_x, cur_y, cur_sh;
   logic [SUM_W-1:0]             pad_s;
   logic                         too_big;
   logic                         width_fail;
   logic                         height_fit;
   logic [SUM_W-1:0]             row_h;

   assign csr_ready = !reset;
   assign req_ready = (step_ff == srp_pkg::S_IDLE) && !reset;
   assign req_take  = req_valid && req_ready;
   assign emit_ok   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_page_num = rsp_page_ff;
   assign rsp_pos_x    = rsp_x_ff;
   assign rsp_pos_y    = rsp_y_ff;

   // Fetch the control word of the current step.
   assign cw = srp_pkg::mc_rom(step_ff);

   // Cursor of the page under test.
   assign p_idx  = page_ff[IDX_W-1:0];
   assign cur_x  = cursor_x_ff[p_idx];
   assign cur_y  = cursor_y_ff[p_idx];
   assign cur_sh = shelf_ff[p_idx];
   assign pad_s  = SUM_W'(padding_ff);

   // Fit tests, formed wide enough that nothing wraps.
   assign too_big = (SUM_W'(rect_w_ff) + pad_s + pad_s + pad_s > SUM_W'(page_width_ff)) ||
                    (SUM_W'(rect_h_ff) + pad_s + pad_s + pad_s > SUM_W'(page_height_ff));
   assign width_fail = SUM_W'(cur_x) + SUM_W'(rect_w_ff) + pad_s + pad_s >
                       SUM_W'(page_width_ff);
   assign height_fit = SUM_W'(cur_y) + SUM_W'(rect_h_ff) + pad_s + pad_s <=
                       SUM_W'(page_height_ff);
   assign row_h      = SUM_W'(rect_h_ff) + pad_s;

   // Condition select for the jump.
   always_comb begin
      unique case (cw.cnd)
         srp_pkg::C_ALWAYS: cond = 1'b1;
         srp_pkg::C_REQ:    cond = req_take;
         srp_pkg::C_BIG:    cond = too_big;
         srp_pkg::C_END:    cond = (page_ff == pages_open_ff);
         srp_pkg::C_FIT:    cond = height_fit;
         srp_pkg::C_FULL:   cond = (pages_open_ff == CNT_W'(MAX_PAGES));
         srp_pkg::C_EMIT:   cond = emit_ok;
         default:           cond = 1'b0;
      endcase
   end

   // Datapath driven by the control word.
   always_comb begin
      step_in        = cond ? cw.jt : cw.jf;
      page_width_in  = page_width_ff;
      page_height_in = page_height_ff;
      padding_in     = padding_ff;
      cursor_x_in    = cursor_x_ff;
      cursor_y_in    = cursor_y_ff;
      shelf_in       = shelf_ff;
      pages_open_in  = pages_open_ff;
      page_in        = page_ff;
      rect_w_in      = rect_w_ff;
      rect_h_in      = rect_h_ff;
      status_in      = status_ff;
      res_page_in    = res_page_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_page_in    = rsp_page_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;

      // Configuration writes; an unknown index is ignored.
      if (csr_valid) begin
         unique case (csr_index)
            srp_pkg::CSR_PAGE_WIDTH:  page_width_in  = csr_wdata;
            srp_pkg::CSR_PAGE_HEIGHT: page_height_in = csr_wdata;
            srp_pkg::CSR_PADDING:     padding_in     = csr_wdata[srp_pkg::PAD_W-1:0];
            default: ;
         endcase
      end

      unique case (cw.op)
         srp_pkg::OP_LOAD: begin
            if (req_take) begin
               rect_w_in   = req_rect_width;
               rect_h_in   = req_rect_height;
               page_in     = '0;
               status_in   = srp_pkg::ST_PLACED;
               res_page_in = '0;
               res_x_in    = '0;
               res_y_in    = '0;
            end
         end
         srp_pkg::OP_BIG: begin
            if (too_big) begin
               status_in = srp_pkg::ST_TOO_BIG;
            end
         end
         srp_pkg::OP_WIDTH: begin
            // Row too short: break to a new shelf, kept even if height fails.
            if (width_fail) begin
               cursor_y_in[p_idx] = DIM_W'(SUM_W'(cur_y) + SUM_W'(cur_sh) + pad_s);
               cursor_x_in[p_idx] = DIM_W'(padding_ff);
               shelf_in[p_idx]    = '0;
            end
         end
         srp_pkg::OP_PLACE: begin
            if (height_fit) begin
               status_in          = srp_pkg::ST_PLACED;
               res_page_in        = PAGE_W'(page_ff);
               res_x_in           = cur_x;
               res_y_in           = cur_y;
               cursor_x_in[p_idx] = DIM_W'(SUM_W'(cur_x) + SUM_W'(rect_w_ff) + pad_s);
               if (row_h > SUM_W'(cur_sh)) begin
                  shelf_in[p_idx] = DIM_W'(row_h);
               end
            end else begin
               // A failure on a freshly opened page stands as too big.
               status_in = srp_pkg::ST_TOO_BIG;
               page_in   = page_ff + CNT_W'(1);
            end
         end
         srp_pkg::OP_OPEN: begin
            if (pages_open_ff == CNT_W'(MAX_PAGES)) begin
               status_in = srp_pkg::ST_FULL;
            end else begin
               cursor_x_in[p_idx] = DIM_W'(padding_ff);
               cursor_y_in[p_idx] = DIM_W'(padding_ff);
               shelf_in[p_idx]    = '0;
               pages_open_in      = pages_open_ff + CNT_W'(1);
            end
         end
         srp_pkg::OP_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_page_in   = res_page_ff;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
            end
         end
         default: ;
      endcase
   end

   // Control state and configuration, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= srp_pkg::S_IDLE;
         page_width_ff  <= srp_pkg::PAGE_DIM_RESET;
         page_height_ff <= srp_pkg::PAGE_DIM_RESET;
         padding_ff     <= srp_pkg::PADDING_RESET;
         pages_open_ff  <= CNT_W'(1);
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < MAX_PAGES; i++) begin
            cursor_x_ff[i] <= DIM_W'(srp_pkg::PADDING_RESET);
            cursor_y_ff[i] <= DIM_W'(srp_pkg::PADDING_RESET);
            shelf_ff[i]    <= '0;
         end
      end else begin
         step_ff        <= step_in;
         page_width_ff  <= page_width_in;
         page_height_ff <= page_height_in;
         padding_ff     <= padding_in;
         pages_open_ff  <= pages_open_in;
         rsp_valid_ff   <= rsp_valid_in;
         cursor_x_ff    <= cursor_x_in;
         cursor_y_ff    <= cursor_y_in;
         shelf_ff       <= shelf_in;
      end
   end

   // Working and output payload.
   always_ff @(posedge clock) begin
      page_ff       <= page_in;
      rect_w_ff     <= rect_w_in;
      rect_h_ff     <= rect_h_in;
      status_ff     <= status_in;
      res_page_ff   <= res_page_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
   end

endmodule

// ===== tb/sv/shelf_rect_packer_unit_tb.sv =====
// Self-checking testbench for the shelf rectangle packer: opening table of words, then
// random words over six atlas settings, checked against a behavioural shelf model or a pinned expectation.
// Depends on srp_pkg and shelf_rect_packer_unit only.

module shelf_rect_packer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_W       = srp_pkg::DIM_W;
   localparam int PAD_W       = srp_pkg::PAD_W;
   localparam int STATUS_W    = srp_pkg::STATUS_W;
   localparam int PAGE_W      = srp_pkg::PAGE_W;
   localparam int CSR_IDX_W   = srp_pkg::CSR_IDX_W;
   localparam int PAGE_COUNT  = srp_pkg::MaxPagesDefault;
   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 400;
   localparam int SQUEEZE_AT  = 3;
   localparam int OPENING_N   = 20;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAGE_W-1:0]   page;
      logic [DIM_W-1:0]    x;
      logic [DIM_W-1:0]    y;
   } placement_type;

   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic             pinned;
      placement_type    want;
   } rect_case_type;

   typedef enum {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_type;

   typedef struct {
      logic [DIM_W-1:0] page_w;
      logic [DIM_W-1:0] page_h;
      logic [PAD_W-1:0] pad;
      int               words;
      pace_type         pace;
      bit               draw;
   } atlas_phase_type;

   localparam placement_type WANT_TOO_BIG = '{srp_pkg::ST_TOO_BIG, 3'd0, 14'd0, 14'd0};
   localparam placement_type WANT_FULL    = '{srp_pkg::ST_FULL, 3'd0, 14'd0, 14'd0};
   localparam placement_type NO_PIN       = '0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [DIM_W-1:0]      req_rect_width = '0;
   logic [DIM_W-1:0]      req_rect_height = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [PAGE_W-1:0]     rsp_page_num;
   logic [DIM_W-1:0]      rsp_pos_x;
   logic [DIM_W-1:0]      rsp_pos_y;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DIM_W-1:0]      csr_wdata = '0;

   // Pinned expectation travelling alongside the request word.
   logic                  req_pinned = 1'b0;
   placement_type         req_pin_want = '0;

   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   logic                  pressure_arm = 1'b0;
   logic                  pressure_seen = 1'b0;
   int                    hold_left = 0;
   int                    quiet_cycles = 0;
   int                    mismatches = 0;

   // Shelf model state and its copy of the registers.
   logic [DIM_W-1:0]      atlas_w;
   logic [DIM_W-1:0]      atlas_h;
   logic [PAD_W-1:0]      atlas_pad;
   logic [DIM_W-1:0]      page_x [PAGE_COUNT];
   logic [DIM_W-1:0]      page_y [PAGE_COUNT];
   logic [DIM_W-1:0]      shelf_h [PAGE_COUNT];
   int                    pages_open;
   // Newest expectation at the front, oldest at the back.
   placement_type         placements_due [$];

   // Opening words, taken with the registers at their reset values.
   rect_case_type opening_words [OPENING_N] = '{
      '{14'd0,    14'd0,    1'b1, '{srp_pkg::ST_PLACED, 3'd0, 14'd1, 14'd1}},
      '{14'd1,    14'd1,    1'b0, NO_PIN},
      '{14'd2046, 14'd1,    1'b1, WANT_TOO_BIG},
      '{14'd1,    14'd2046, 1'b1, WANT_TOO_BIG},
      '{14'd8192, 14'd8192, 1'b1, WANT_TOO_BIG},
      '{14'd8192, 14'd0,    1'b1, WANT_TOO_BIG},
      '{14'd0,    14'd8192, 1'b1, WANT_TOO_BIG},
      '{14'd5461, 14'd2730, 1'b1, WANT_TOO_BIG},
      '{14'd2730, 14'd5461, 1'b1, WANT_TOO_BIG},
      '{14'd2045, 14'd2045, 1'b0, NO_PIN},
      '{14'd2045, 14'd2045, 1'b0, NO_PIN},
      '{14'd2045, 14'd2045, 1'b0, NO_PIN},
      '{14'd2045, 14'd2045, 1'b0, NO_PIN},
      '{14'd2045, 14'd2045, 1'b0, NO_PIN},
      '{14'd2045, 14'd2045, 1'b0, NO_PIN},
      '{14'd2045, 14'd2045, 1'b0, NO_PIN},
      '{14'd2045, 14'd2045, 1'b1, WANT_FULL},
      '{14'd0,    14'd0,    1'b0, NO_PIN},
      '{14'd2045, 14'd0,    1'b0, NO_PIN},
      '{14'd1000, 14'd500,  1'b0, NO_PIN}
   };

   // Register settings for the random part; the drawn one is picked at run time.
   atlas_phase_type atlas_phases [6] = '{
      '{14'd4096, 14'd4096, 4'd0,  320, PACE_RX_SLOW, 1'b0},
      '{14'd8192, 14'd3000, 4'd15, 320, PACE_RX_SLOW, 1'b0},
      '{14'd1,    14'd1,    4'd0,  30,  PACE_TX_SLOW, 1'b0},
      '{14'd8192, 14'd8192, 4'd3,  400, PACE_TX_SLOW, 1'b0},
      '{14'd0,    14'd0,    4'd0,  400, PACE_FULL,    1'b1},
      '{14'd2048, 14'd2048, 4'd1,  450, PACE_FULL,    1'b0}
   };

   shelf_rect_packer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_page_num    (rsp_page_num),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Try one page: break the shelf when the row is too short, then check the height.
   // The shelf break is kept even when the height check fails.
   function automatic bit shelf_fits(input int p, input logic [31:0] w, input logic [31:0] h,
                                     output logic [DIM_W-1:0] px, output logic [DIM_W-1:0] py);
      logic [31:0] span_w;
      logic [31:0] span_h;
      logic [31:0] sum;
      px = '0;
      py = '0;
      span_w = w + 32'(atlas_pad);
      span_h = h + 32'(atlas_pad);
      if (32'(page_x[p]) + span_w + 32'(atlas_pad) > 32'(atlas_w)) begin
         sum = 32'(page_y[p]) + 32'(shelf_h[p]) + 32'(atlas_pad);
         page_y[p] = sum[DIM_W-1:0];
         page_x[p] = DIM_W'(atlas_pad);
         shelf_h[p] = '0;
      end
      if (32'(page_y[p]) + span_h + 32'(atlas_pad) > 32'(atlas_h))
         return 1'b0;
      px = page_x[p];
      py = page_y[p];
      sum = 32'(page_x[p]) + span_w;
      page_x[p] = sum[DIM_W-1:0];
      if (span_h > 32'(shelf_h[p]))
         shelf_h[p] = span_h[DIM_W-1:0];
      return 1'b1;
   endfunction

   // First fit over the open pages, then a fresh page if one is left.
   function automatic placement_type place_rect(input logic [DIM_W-1:0] w_in,
                                                input logic [DIM_W-1:0] h_in);
      placement_type    r;
      logic [31:0]      w;
      logic [31:0]      h;
      logic [DIM_W-1:0] px;
      logic [DIM_W-1:0] py;
      bit               done;
      int               p;
      r = '0;
      r.status = srp_pkg::ST_PLACED;
      w = 32'(w_in);
      h = 32'(h_in);
      done = 1'b0;
      if (w + 3 * 32'(atlas_pad) > 32'(atlas_w) || h + 3 * 32'(atlas_pad) > 32'(atlas_h)) begin
         r.status = srp_pkg::ST_TOO_BIG;
         done = 1'b1;
      end
      for (p = 0; !done && p < pages_open; p++) begin
         if (shelf_fits(p, w, h, px, py)) begin
            r.page = p[PAGE_W-1:0];
            r.x = px;
            r.y = py;
            done = 1'b1;
         end
      end
      if (!done) begin
         if (pages_open < PAGE_COUNT) begin
            p = pages_open;
            page_x[p] = DIM_W'(atlas_pad);
            page_y[p] = DIM_W'(atlas_pad);
            shelf_h[p] = '0;
            pages_open++;
            if (shelf_fits(p, w, h, px, py)) begin
               r.page = p[PAGE_W-1:0];
               r.x = px;
               r.y = py;
            end else begin
               r.status = srp_pkg::ST_TOO_BIG;
            end
         end else begin
            r.status = srp_pkg::ST_FULL;
         end
      end
      if (r.status != srp_pkg::ST_PLACED) begin
         r.page = '0;
         r.x = '0;
         r.y = '0;
      end
      return r;
   endfunction

   task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // Follow every handshake: register writes update the model, request words
   // queue an expectation, result words are checked against the oldest one.
   always @(posedge clock) begin
      placement_type seen;
      placement_type due;
      int            p;
      if (reset) begin
         atlas_w = srp_pkg::PAGE_DIM_RESET;
         atlas_h = srp_pkg::PAGE_DIM_RESET;
         atlas_pad = srp_pkg::PADDING_RESET;
         for (p = 0; p < PAGE_COUNT; p++) begin
            page_x[p] = DIM_W'(srp_pkg::PADDING_RESET);
            page_y[p] = DIM_W'(srp_pkg::PADDING_RESET);
            shelf_h[p] = '0;
         end
         pages_open = 1;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               srp_pkg::CSR_PAGE_WIDTH:  atlas_w = csr_wdata;
               srp_pkg::CSR_PAGE_HEIGHT: atlas_h = csr_wdata;
               srp_pkg::CSR_PADDING:     atlas_pad = csr_wdata[PAD_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_status, rsp_page_num, rsp_pos_x, rsp_pos_y};
            if (placements_due.size() == 0) begin
               $display("%0t: result word with nothing due: status %0d page %0d x %0d y %0d",
                        $time, seen.status, seen.page, seen.x, seen.y);
               mismatches++;
            end else begin
               due = placements_due.pop_back();
               flag_field("status", due.status, seen.status);
               flag_field("page number", due.page, seen.page);
               flag_field("pos_x", due.x, seen.x);
               flag_field("pos_y", due.y, seen.y);
            end
         end
         if (req_valid && req_ready) begin
            due = place_rect(req_rect_width, req_rect_height);
            placements_due.push_front(req_pinned ? req_pin_want : due);
         end
      end
   end

   // Result side: random back-pressure, plus one long hold-off when armed.
   always @(posedge clock) begin
      if (pressure_arm && !pressure_seen) begin
         pressure_seen <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Give up when no word of any kind has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_RX_SLOW: begin
            send_idle_pct = 15;
            recv_idle_pct <= 54;
         end
         PACE_TX_SLOW: begin
            send_idle_pct = 54;
            recv_idle_pct <= 15;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
         end
      endcase
   endtask

   // Offer one request word; valid is only lowered when the sender idles.
   task automatic send_rect(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input logic pinned, input placement_type want);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rect_width <= w;
      req_rect_height <= h;
      req_pinned <= pinned;
      req_pin_want <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait until every result word has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (placements_due.size() != 0) @(posedge clock);
   endtask

   // Write all three registers back to back, valid held high throughout.
   task automatic program_atlas(input logic [DIM_W-1:0] pw, input logic [DIM_W-1:0] ph,
                                input logic [PAD_W-1:0] pad);
      logic [CSR_IDX_W-1:0] regs [3];
      logic [DIM_W-1:0]     vals [3];
      int                   i;
      regs = '{srp_pkg::CSR_PAGE_WIDTH, srp_pkg::CSR_PAGE_HEIGHT, srp_pkg::CSR_PADDING};
      vals = '{pw, ph, {{(DIM_W-PAD_W){1'b0}}, pad}};
      csr_valid <= 1'b1;
      for (i = 0; i < 3; i++) begin
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly small rectangles, some medium and large, and some sized right at
   // the largest that an empty page still takes, give or take one.
   task automatic pick_rect(input atlas_phase_type stage, output logic [DIM_W-1:0] w,
                            output logic [DIM_W-1:0] h);
      int rim_w;
      int rim_h;
      rim_w = int'(stage.page_w) - 3 * int'(stage.pad) + int'($urandom_range(0, 2)) - 1;
      rim_h = int'(stage.page_h) - 3 * int'(stage.pad) + int'($urandom_range(0, 2)) - 1;
      rim_w = (rim_w < 0) ? 0 : (rim_w > 8192) ? 8192 : rim_w;
      rim_h = (rim_h < 0) ? 0 : (rim_h > 8192) ? 8192 : rim_h;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            w = DIM_W'($urandom_range(0, 255));
            h = DIM_W'($urandom_range(0, 255));
         end
         6, 7: begin
            w = DIM_W'($urandom_range(0, 2047));
            h = DIM_W'($urandom_range(0, 2047));
         end
         8: begin
            w = DIM_W'($urandom_range(0, 8192));
            h = DIM_W'($urandom_range(0, 8192));
         end
         default: begin
            w = rim_w[DIM_W-1:0];
            h = ($urandom_range(0, 1) != 0) ? rim_h[DIM_W-1:0] :
                                              DIM_W'($urandom_range(0, 255));
         end
      endcase
   endtask

   initial begin
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      atlas_phase_type  stage;
      int               k;
      int               n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Opening table at the reset register values.
      set_pace(PACE_RX_SLOW);
      for (n = 0; n < OPENING_N; n++)
         send_rect(opening_words[n].w, opening_words[n].h, opening_words[n].pinned,
                   opening_words[n].want);

      // Random words, one register setting per phase, written while idle.
      for (k = 0; k < 6; k++) begin
         stage = atlas_phases[k];
         if (stage.draw) begin
            stage.page_w = DIM_W'($urandom_range(1, 8192));
            stage.page_h = DIM_W'($urandom_range(1, 8192));
            stage.pad = PAD_W'($urandom_range(0, 15));
         end
         drain_results();
         program_atlas(stage.page_w, stage.page_h, stage.pad);
         set_pace(stage.pace);
         if (k == SQUEEZE_AT)
            pressure_arm <= 1'b1;
         for (n = 0; n < stage.words; n++) begin
            pick_rect(stage, w, h);
            send_rect(w, h, 1'b0, NO_PIN);
         end
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== shelf_rect_packer_unit.f =====
hdl/srp_pkg.sv
hdl/shelf_rect_packer_unit.sv
tb/sv/shelf_rect_packer_unit_tb.sv
